@@ design/sams_pkg.sv @@
// Package for the slot allocator with mark-and-sweep reclamation.
// Holds pool sizes, operation and status codes, FSM states and the
// controller/datapath interface structs. No dependencies.
`default_nettype none

package sams_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int TYPE_BITS  = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_MARK  = 2'd1,
        MODE_SWEEP = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOT_LIVE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_SWEEP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_start;
        logic sweep_step;
        logic sweep_finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sweep;
        logic sweep_end;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ design/slot_allocator_mark_sweep.sv @@
// Top level of the slot allocator with mark-and-sweep reclamation.
// Depends on sams_pkg, sams_ctrl and sams_dp.
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | slot_number[7:0], type_tag[23:8]            | mode[1:0]
//  m_axis   | out       | granted_slot[7:0], freed_count[16:8],       | status[1:0]
//           |           | live_count[25:17], pool_full[26],           |
//           |           | pool_empty[27], pad to 32                   |
//
// Allocate, mark and the unused mode are loaded in the idle state and execute
// in the op state once the output register is free. A sweep visits one slot per
// cycle, since the free-list link memory has a single write port.
// Input is taken only while the controller is idle; a result may wait in
// the output register while the next item is transferred in.
// Reset is synchronous and clears the list head, the high-water mark and the
// count. Slots at or above the high-water mark read as free, so the slot flag
// memories need no clearing pass.
`default_nettype none

module slot_allocator_mark_sweep (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // slot_number, type_tag
    input  wire logic [1:0]  s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // granted_slot, freed_count, live_count,
                                             // pool_full, pool_empty
    output logic [1:0]       m_axis_tuser    // status
);

    sams_pkg::t_cmd  cmd;
    sams_pkg::t_stat stat;

    logic [sams_pkg::SLOT_W-1:0] granted;
    logic [sams_pkg::CNT_W-1:0]  freed;
    logic [sams_pkg::CNT_W-1:0]  live;
    logic                        full;
    logic                        empty;

    sams_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sams_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (s_axis_tuser),
        .i_slot      (s_axis_tdata[7:0]),
        .i_tag       (s_axis_tdata[23:8]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_granted   (granted),
        .o_freed     (freed),
        .o_live      (live),
        .o_full      (full),
        .o_empty     (empty)
    );

    assign m_axis_tdata = {4'b0000, empty, full, live, freed, granted};

endmodule

`default_nettype wire

@@ design/sams_ctrl.sv @@
// Controller state machine of the slot allocator.
// Depends on sams_pkg for states and the command and status structs.
`default_nettype none

module sams_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire sams_pkg::t_stat i_stat,
    output sams_pkg::t_cmd       o_cmd
);

    sams_pkg::t_state r_state;
    sams_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sams_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sams_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sams_pkg::S_OP;
                end
            end
            sams_pkg::S_OP: begin
                if (i_stat.is_sweep) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = sams_pkg::S_SWEEP;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = sams_pkg::S_IDLE;
                end
            end
            sams_pkg::S_SWEEP: begin
                if (!i_stat.sweep_end) begin
                    o_cmd.sweep_step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.sweep_finish = 1'b1;
                    n_state            = sams_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sams_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/sams_dp.sv @@
// Datapath of the slot allocator: slot flag memories, free-list link memory,
// type memory, sweep counter and the result register. Depends on sams_pkg.
`default_nettype none

module sams_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sams_pkg::t_cmd                  i_cmd,
    output sams_pkg::t_stat                      o_stat,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [sams_pkg::SLOT_W-1:0]     i_slot,
    input  wire logic [sams_pkg::TYPE_BITS-1:0]  i_tag,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [1:0]                           o_status,
    output logic [sams_pkg::SLOT_W-1:0]          o_granted,
    output logic [sams_pkg::CNT_W-1:0]           o_freed,
    output logic [sams_pkg::CNT_W-1:0]           o_live,
    output logic                                 o_full,
    output logic                                 o_empty
);

    localparam logic [sams_pkg::CNT_W-1:0] SlotCnt = sams_pkg::CNT_W'(sams_pkg::SLOT_COUNT);
    localparam logic [sams_pkg::CNT_W-1:0] One     = sams_pkg::CNT_W'(1);

    // Per-slot flags. Slots at or above the high-water mark were never
    // allocated and count as free whatever these memories hold.
    logic                           live_mem [sams_pkg::SLOT_COUNT];
    logic                           mark_mem [sams_pkg::SLOT_COUNT];
    logic                           r_live_rd;
    logic                           r_mark_rd;

    logic [sams_pkg::CNT_W-1:0] r_head;
    logic [sams_pkg::CNT_W-1:0] r_hw;
    logic [sams_pkg::CNT_W-1:0] r_count;
    logic [sams_pkg::CNT_W-1:0] r_idx;
    logic [sams_pkg::CNT_W-1:0] r_freed;

    logic [1:0]                       r_mode;
    logic [sams_pkg::SLOT_W-1:0]      r_slot;
    logic [sams_pkg::TYPE_BITS-1:0]   r_tag;

    logic [sams_pkg::CNT_W-1:0]     link_mem [sams_pkg::SLOT_COUNT];
    logic [sams_pkg::TYPE_BITS-1:0] type_mem [sams_pkg::SLOT_COUNT];
    logic [sams_pkg::CNT_W-1:0]     r_link_rd;

    logic                           r_out_valid;
    logic [1:0]                     r_status;
    logic [sams_pkg::SLOT_W-1:0]    r_granted;
    logic [sams_pkg::CNT_W-1:0]     r_freed_out;
    logic [sams_pkg::CNT_W-1:0]     r_live_out;
    logic                           r_full;
    logic                           r_empty;

    logic                           alloc_ok;
    logic                           alloc_full;
    logic                           mark_ok;
    logic [sams_pkg::SLOT_W-1:0]    head_slot;
    logic [sams_pkg::SLOT_W-1:0]    idx_slot;
    logic [sams_pkg::SLOT_W-1:0]    flag_addr;
    logic                           flag_rd_en;
    logic                           step_free;
    logic [sams_pkg::CNT_W-1:0]     n_count;
    logic [1:0]                     n_status;
    logic                           load_result;

    assign head_slot = r_head[sams_pkg::SLOT_W-1:0];
    assign idx_slot  = r_idx[sams_pkg::SLOT_W-1:0];

    always_comb begin
        alloc_full = (r_count >= SlotCnt) || (r_head >= SlotCnt);
        alloc_ok   = 1'b0;
        mark_ok    = 1'b0;
        n_status   = sams_pkg::STAT_OK;
        n_count    = r_count;
        case (sams_pkg::t_mode'(r_mode))
            sams_pkg::MODE_ALLOC: begin
                if (alloc_full) begin
                    n_status = sams_pkg::STAT_FULL;
                end else begin
                    alloc_ok = 1'b1;
                    n_count  = r_count + One;
                end
            end
            sams_pkg::MODE_MARK: begin
                if ((sams_pkg::CNT_W'(r_slot) < r_hw) && r_live_rd) begin
                    mark_ok = 1'b1;
                end else begin
                    n_status = sams_pkg::STAT_NOT_LIVE;
                end
            end
            default: begin
                n_status = sams_pkg::STAT_OK;
            end
        endcase
    end

    // The flags of the mark target are fetched when the item is transferred in.
    // During a sweep they are fetched one slot ahead of the slot being updated.
    always_comb begin
        if (i_cmd.load) begin
            flag_addr = i_slot;
        end else if (i_cmd.sweep_start) begin
            flag_addr = '0;
        end else begin
            flag_addr = idx_slot + sams_pkg::SLOT_W'(1);
        end
    end

    assign flag_rd_en  = i_cmd.load || i_cmd.sweep_start || i_cmd.sweep_step;
    assign step_free   = i_cmd.sweep_step && r_live_rd && !r_mark_rd;
    assign load_result = i_cmd.exec || i_cmd.sweep_finish;

    assign o_stat.is_sweep  = (r_mode == sams_pkg::MODE_SWEEP);
    assign o_stat.sweep_end = (r_idx == r_hw);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_slot <= i_slot;
            r_tag  <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (flag_rd_en) begin
            r_live_rd <= live_mem[flag_addr];
            r_mark_rd <= mark_mem[flag_addr];
        end
        if (i_cmd.exec && alloc_ok) begin
            live_mem[head_slot] <= 1'b1;
            mark_mem[head_slot] <= 1'b0;
        end else if (i_cmd.exec && mark_ok) begin
            mark_mem[r_slot] <= 1'b1;
        end else if (i_cmd.sweep_step) begin
            live_mem[idx_slot] <= r_live_rd && r_mark_rd;
            mark_mem[idx_slot] <= 1'b0;
        end
    end

    // The link memory is read at the free-list head every cycle, so the
    // successor of the head is ready when an allocate executes.
    always_ff @(posedge i_clk) begin
        r_link_rd <= link_mem[head_slot];
        if (step_free) begin
            link_mem[idx_slot] <= r_head;
        end
        if (i_cmd.exec && alloc_ok) begin
            type_mem[head_slot] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_hw     <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_freed  <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
                if (alloc_ok) begin
                    if (r_hw == r_head) begin
                        r_hw   <= r_hw + One;
                        r_head <= r_hw + One;
                    end else begin
                        r_head <= r_link_rd;
                    end
                end
            end
            if (i_cmd.sweep_start) begin
                r_idx   <= '0;
                r_freed <= '0;
            end
            if (i_cmd.sweep_step) begin
                r_idx <= r_idx + One;
                if (step_free) begin
                    r_head  <= r_idx;
                    r_freed <= r_freed + One;
                    if (r_count != '0) begin
                        r_count <= r_count - One;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_granted   <= alloc_ok ? head_slot : '0;
            r_freed_out <= '0;
            r_live_out  <= n_count;
            r_full      <= (n_count >= SlotCnt);
            r_empty     <= (n_count == '0);
        end else if (i_cmd.sweep_finish) begin
            r_status    <= sams_pkg::STAT_OK;
            r_granted   <= '0;
            r_freed_out <= r_freed;
            r_live_out  <= r_count;
            r_full      <= (r_count >= SlotCnt);
            r_empty     <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_granted   = r_granted;
    assign o_freed     = r_freed_out;
    assign o_live      = r_live_out;
    assign o_full      = r_full;
    assign o_empty     = r_empty;

    // Every allocated slot lies below the high-water mark.
    a_count_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_hw)
        else $error("allocated count above high-water mark");

    // The free-list head is either a used slot or the first fresh one.
    a_head_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_hw)
        else $error("free-list head above high-water mark");

    // The sweep never visits a slot at or above the high-water mark.
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep_step |-> (r_idx < r_hw))
        else $error("sweep index past high-water mark");

    // A granted slot lies below the high-water mark after the allocate.
    a_alloc_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && alloc_ok) |=> ($past(r_head) < r_hw))
        else $error("allocated slot above high-water mark");

endmodule

`default_nettype wire
